// File: sv/hprd_pkg.sv
package hprd_pkg;

    localparam int AVG_DEPTH_DEF = 5;
    localparam int RATE_NUM = 3000;
    localparam int RATE_MAX = 255;
    localparam int RISE_COUNT_LIMIT = 3;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        REG_LEFT_RISE_MARGIN  = 3'd0,
        REG_RIGHT_RISE_MARGIN = 3'd1,
        REG_MAX_VALLEY_SPAN   = 3'd2,
        REG_MIN_AMPLITUDE     = 3'd3,
        REG_MIN_PEAK_SPACING  = 3'd4,
        REG_MIN_INTERVAL      = 3'd5,
        REG_MAX_INTERVAL      = 3'd6,
        REG_SILENCE_LIMIT     = 3'd7
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DETECT,
        ST_UPDATE,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [15:0] sample;
        logic [31:0] time_index;
    } t_in;

    typedef struct packed {
        logic        beat_found;
        logic [31:0] beat_time;
        logic [7:0]  avg_rate;
    } t_out;

    typedef struct packed {
        logic [7:0]  left_rise_margin;
        logic [7:0]  right_rise_margin;
        logic [7:0]  max_valley_span;
        logic [15:0] min_amplitude;
        logic [7:0]  min_peak_spacing;
        logic [7:0]  min_interval;
        logic [7:0]  max_interval;
        logic [15:0] silence_limit;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic detect;
        logic update;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic div_needed;
        logic div_last;
        logic out_free;
    } t_stat;

endpackage

// File: sv/hprd_regs.sv
module hprd_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hprd_pkg::ADDR_W-1:0]  paddr,
    input  logic [hprd_pkg::DATA_W-1:0]  pwdata,
    output logic [hprd_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output hprd_pkg::t_cfg               o_cfg
);

    hprd_pkg::t_cfg   r_cfg;
    hprd_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_idx  = hprd_pkg::t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.left_rise_margin  <= 8'd3;
            r_cfg.right_rise_margin <= 8'd5;
            r_cfg.max_valley_span   <= 8'd18;
            r_cfg.min_amplitude     <= 16'd50;
            r_cfg.min_peak_spacing  <= 8'd20;
            r_cfg.min_interval      <= 8'd25;
            r_cfg.max_interval      <= 8'd100;
            r_cfg.silence_limit     <= 16'd500;
        end else if (w_wr) begin
            case (w_idx)
                hprd_pkg::REG_LEFT_RISE_MARGIN:  r_cfg.left_rise_margin  <= pwdata[7:0];
                hprd_pkg::REG_RIGHT_RISE_MARGIN: r_cfg.right_rise_margin <= pwdata[7:0];
                hprd_pkg::REG_MAX_VALLEY_SPAN:   r_cfg.max_valley_span   <= pwdata[7:0];
                hprd_pkg::REG_MIN_AMPLITUDE:     r_cfg.min_amplitude     <= pwdata[15:0];
                hprd_pkg::REG_MIN_PEAK_SPACING:  r_cfg.min_peak_spacing  <= pwdata[7:0];
                hprd_pkg::REG_MIN_INTERVAL:      r_cfg.min_interval      <= pwdata[7:0];
                hprd_pkg::REG_MAX_INTERVAL:      r_cfg.max_interval      <= pwdata[7:0];
                hprd_pkg::REG_SILENCE_LIMIT:     r_cfg.silence_limit     <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            hprd_pkg::REG_LEFT_RISE_MARGIN:  prdata = {24'd0, r_cfg.left_rise_margin};
            hprd_pkg::REG_RIGHT_RISE_MARGIN: prdata = {24'd0, r_cfg.right_rise_margin};
            hprd_pkg::REG_MAX_VALLEY_SPAN:   prdata = {24'd0, r_cfg.max_valley_span};
            hprd_pkg::REG_MIN_AMPLITUDE:     prdata = {16'd0, r_cfg.min_amplitude};
            hprd_pkg::REG_MIN_PEAK_SPACING:  prdata = {24'd0, r_cfg.min_peak_spacing};
            hprd_pkg::REG_MIN_INTERVAL:      prdata = {24'd0, r_cfg.min_interval};
            hprd_pkg::REG_MAX_INTERVAL:      prdata = {24'd0, r_cfg.max_interval};
            hprd_pkg::REG_SILENCE_LIMIT:     prdata = {16'd0, r_cfg.silence_limit};
            default:                         prdata = '0;
        endcase
    end

endmodule

// File: sv/hprd_ctrl.sv
module hprd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  hprd_pkg::t_stat i_stat,
    output hprd_pkg::t_cmd  o_cmd
);

    hprd_pkg::t_state r_state;
    hprd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hprd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            hprd_pkg::ST_IDLE: begin
                if (i_valid) n_state = hprd_pkg::ST_DETECT;
            end
            hprd_pkg::ST_DETECT: n_state = hprd_pkg::ST_UPDATE;
            hprd_pkg::ST_UPDATE: begin
                n_state = i_stat.div_needed ? hprd_pkg::ST_DIV : hprd_pkg::ST_DONE;
            end
            hprd_pkg::ST_DIV: begin
                if (i_stat.div_last) n_state = hprd_pkg::ST_DONE;
            end
            hprd_pkg::ST_DONE: begin
                if (i_stat.out_free) n_state = hprd_pkg::ST_IDLE;
            end
            default: n_state = hprd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            hprd_pkg::ST_IDLE: begin
                o_stall    = !i_rst_n;
                o_cmd.load = i_valid && i_rst_n;
            end
            hprd_pkg::ST_DETECT: o_cmd.detect   = 1'b1;
            hprd_pkg::ST_UPDATE: o_cmd.update   = 1'b1;
            hprd_pkg::ST_DIV:    o_cmd.div_step = 1'b1;
            hprd_pkg::ST_DONE:   o_cmd.out_load = i_stat.out_free;
            default: begin
            end
        endcase
    end

endmodule

// File: sv/hprd_dp.sv
module hprd_dp #(
    parameter int AVG_DEPTH = hprd_pkg::AVG_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hprd_pkg::t_cfg  i_cfg,
    input  hprd_pkg::t_cmd  i_cmd,
    output hprd_pkg::t_stat o_stat,
    input  hprd_pkg::t_in   i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output hprd_pkg::t_out  o_data
);

    localparam int SW = $clog2(AVG_DEPTH * 255 + 1);
    localparam int W  = SW + 9;
    localparam int IW = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam logic [W-1:0] DIVIDEND = W'(hprd_pkg::RATE_NUM * AVG_DEPTH);
    localparam logic [7:0] RMAX = 8'(hprd_pkg::RATE_MAX);
    localparam logic [7:0] RLIM = 8'(hprd_pkg::RISE_COUNT_LIMIT);

    logic [15:0] r_x;
    logic [31:0] r_t;

    logic        r_started, r_seek, r_rvs, r_rms;
    logic [15:0] r_pk, r_lv, r_rv, r_rmax, r_rmin;
    logic [31:0] r_pt, r_lpt, r_lvt, r_rvt, r_rmt;
    logic [7:0]  r_rrc, r_rmc;
    logic        n_started, n_seek, n_rvs, n_rms;
    logic [15:0] n_pk, n_lv, n_rv, n_rmax, n_rmin;
    logic [31:0] n_pt, n_lpt, n_lvt, n_rvt, n_rmt;
    logic [7:0]  n_rrc, n_rmc;
    logic        n_det;

    logic        r_beat;
    logic [31:0] r_when;
    logic [31:0] r_prev;
    logic [7:0]  r_store [AVG_DEPTH];
    logic [IW-1:0] r_idx;
    logic [SW-1:0] r_sum;
    logic [15:0] r_silent;
    logic [7:0]  r_rate;

    logic [W-1:0] r_rem, r_dsr;
    logic [7:0]   r_q;
    logic         r_sat;
    logic [3:0]   r_cnt;

    logic         r_ov;
    hprd_pkg::t_out r_out;

    logic [31:0] w_d;
    logic        w_inwin;
    logic [15:0] w_silent;
    logic [SW-1:0] w_sum;
    logic [7:0]  w_inc_m, w_inc_r;
    logic [15:0] w_diff, w_dr, w_dl, w_small;
    logic        w_pass;
    logic [W-1:0] w_sub;
    logic         w_ge;
    logic [7:0]   w_qn;

    always_comb begin
        n_started = r_started; n_seek = r_seek; n_rvs = r_rvs; n_rms = r_rms;
        n_pk = r_pk; n_lv = r_lv; n_rv = r_rv; n_rmax = r_rmax; n_rmin = r_rmin;
        n_pt = r_pt; n_lpt = r_lpt; n_lvt = r_lvt; n_rvt = r_rvt; n_rmt = r_rmt;
        n_rrc = r_rrc; n_rmc = r_rmc;
        n_det = 1'b0;
        w_inc_m = r_rmc + 8'd1;
        w_inc_r = r_rrc + 8'd1;
        w_diff  = (r_rv > r_lv) ? (r_rv - r_lv) : (r_lv - r_rv);
        w_dr    = r_pk - r_rv;
        w_dl    = r_pk - r_lv;
        w_small = (w_dr < w_dl) ? w_dr : w_dl;
        w_pass  = ((r_rvt - r_lvt) <= {24'd0, i_cfg.max_valley_span})
            && (({3'd0, w_diff} + {1'b0, w_diff, 2'b00}) < {1'b0, w_small, 2'b00})
            && (r_pk > r_lv) && (w_dl > i_cfg.min_amplitude)
            && ((r_pt - r_lpt) > {24'd0, i_cfg.min_peak_spacing});
        if (!r_started) begin
            n_started = 1'b1;
            n_pk = r_x; n_rv = r_x; n_lv = r_x; n_rmax = r_x; n_rmin = r_x;
            n_rvt = r_t; n_lvt = r_t; n_pt = r_t; n_lpt = r_t;
            n_rvs = 1'b0; n_rrc = 8'd0; n_rms = 1'b0; n_rmc = 8'd0;
            n_seek = 1'b1;
        end else if (r_seek) begin
            if (r_x > r_rmax) begin
                n_rmax = r_x;
            end else if (!r_rms) begin
                n_rmin = r_x; n_rms = 1'b1;
            end else if (r_x <= r_rmin) begin
                n_rmin = r_x; n_rmt = r_t; n_rmc = 8'd0;
            end else begin
                n_rmc = w_inc_m;
                if (w_inc_m >= RLIM
                    || {1'b0, r_x} > ({1'b0, r_rmin} + {9'd0, i_cfg.left_rise_margin})) begin
                    n_lv = r_rmin; n_lvt = r_rmt;
                    n_pk = r_x; n_pt = r_t;
                    n_seek = 1'b0; n_rms = 1'b0;
                end
            end
        end else begin
            if (r_x > r_pk && !r_rvs) begin
                n_pk = r_x; n_pt = r_t;
            end else if (!r_rvs) begin
                n_rv = r_x; n_rvt = r_t; n_rvs = 1'b1;
            end else if (r_x <= r_rv) begin
                n_rv = r_x; n_rvt = r_t; n_rrc = 8'd0;
            end else begin
                n_rrc = w_inc_r;
                if (w_inc_r >= RLIM
                    || {1'b0, r_x} > ({1'b0, r_rv} + {9'd0, i_cfg.right_rise_margin})) begin
                    if (w_pass) begin
                        n_lpt = r_pt; n_seek = 1'b1; n_rvs = 1'b0;
                        n_rmax = r_x; n_rmin = r_x;
                        n_det = 1'b1;
                    end else begin
                        n_lv = r_rv; n_lvt = r_rvt;
                        n_pk = r_x; n_pt = r_t;
                        n_rvs = 1'b0;
                    end
                end
            end
        end
    end

    assign w_d      = r_when - r_prev;
    assign w_inwin  = (w_d > {24'd0, i_cfg.min_interval}) && (w_d < {24'd0, i_cfg.max_interval});
    assign w_silent = (r_silent == 16'hFFFF) ? r_silent : r_silent + 16'd1;
    assign w_sum    = r_sum - SW'(r_store[r_idx]) + SW'(w_d[7:0]);
    assign w_ge     = r_rem >= r_dsr;
    assign w_sub    = w_ge ? r_rem - r_dsr : r_rem;
    assign w_qn     = {r_q[6:0], w_ge};

    assign o_stat.div_needed = r_beat && w_inwin;
    assign o_stat.div_last   = (r_cnt == 4'd8);
    assign o_stat.out_free   = !r_ov || !i_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= i_data.sample;
            r_t <= i_data.time_index;
        end
        if (i_cmd.detect) begin
            r_pk <= n_pk; r_lv <= n_lv; r_rv <= n_rv; r_rmax <= n_rmax; r_rmin <= n_rmin;
            r_pt <= n_pt; r_lpt <= n_lpt; r_lvt <= n_lvt; r_rvt <= n_rvt;
            r_when <= r_pt;
        end
        if (i_cmd.div_step) begin
            if (r_cnt == 4'd0) begin
                r_rem <= DIVIDEND;
                r_dsr <= {2'b00, r_sum, 7'd0};
                r_q   <= 8'd0;
                r_sat <= (r_sum == '0) || (DIVIDEND >= {1'b0, r_sum, 8'd0});
            end else begin
                r_rem <= w_sub;
                r_dsr <= r_dsr >> 1;
                r_q   <= w_qn;
            end
        end
        if (i_cmd.out_load) begin
            r_out.beat_found <= r_beat;
            r_out.beat_time  <= r_beat ? r_when : 32'd0;
            r_out.avg_rate   <= r_rate;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0; r_seek <= 1'b1; r_rvs <= 1'b0; r_rms <= 1'b0;
            r_rrc <= 8'd0; r_rmc <= 8'd0; r_rmt <= 32'd0;
            r_beat <= 1'b0; r_prev <= 32'd0;
            r_idx <= '0; r_sum <= '0; r_silent <= 16'd0; r_rate <= 8'd0;
            r_cnt <= 4'd0; r_ov <= 1'b0;
            for (int i = 0; i < AVG_DEPTH; i++) r_store[i] <= 8'd0;
        end else begin
            if (i_cmd.detect) begin
                r_started <= n_started; r_seek <= n_seek; r_rvs <= n_rvs; r_rms <= n_rms;
                r_rrc <= n_rrc; r_rmc <= n_rmc; r_rmt <= n_rmt;
                r_beat <= n_det && (r_pt != 32'd0);
            end
            if (i_cmd.update) begin
                r_cnt <= 4'd0;
                if (r_beat) begin
                    if (w_inwin) begin
                        r_sum <= w_sum;
                        r_store[r_idx] <= w_d[7:0];
                        r_idx <= (r_idx == IW'(AVG_DEPTH - 1)) ? '0 : r_idx + 1'b1;
                    end
                    r_silent <= 16'd0;
                    r_prev   <= r_when;
                end else begin
                    r_silent <= w_silent;
                    if (w_silent > i_cfg.silence_limit) r_rate <= 8'd0;
                end
            end
            if (i_cmd.div_step) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd8) r_rate <= r_sat ? RMAX : w_qn;
            end
            if (i_cmd.out_load) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;

`ifndef SYNTH
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_ov || !i_stall))
        else $error("result loaded over an untaken result");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= IW'(AVG_DEPTH - 1))
        else $error("interval index out of range");
    a_silence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && !r_beat && w_silent > i_cfg.silence_limit) |=> (r_rate == 8'd0))
        else $error("rate not cleared after silence");
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_cnt <= 4'd8))
        else $error("divider ran past its last step");
`endif

endmodule

// File: sv/heartbeat_peak_rate_detector.sv
// Takes one transaction of sample and time index and returns one result transaction with
// the beat flag, the peak time and the averaged rate. An item passes through the detect,
// update and done states from acceptance to the next acceptance, and also through the
// divide state when a beat interval enters the average, since the rate is then computed
// by a restoring divider that produces one quotient bit per cycle after a saturation check.
// A finished result waits in an output register, so the next transaction is accepted while it is still held.
module heartbeat_peak_rate_detector #(
    parameter int AVG_DEPTH = hprd_pkg::AVG_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  hprd_pkg::t_in                i_data,
    output logic                         o_valid,
    input  logic                         i_stall,
    output hprd_pkg::t_out               o_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hprd_pkg::ADDR_W-1:0]  paddr,
    input  logic [hprd_pkg::DATA_W-1:0]  pwdata,
    output logic [hprd_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);

    hprd_pkg::t_cfg  w_cfg;
    hprd_pkg::t_cmd  w_cmd;
    hprd_pkg::t_stat w_stat;

    hprd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    hprd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    hprd_dp #(
        .AVG_DEPTH (AVG_DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule
